FILE: src/sirt_pkg.sv
// ----------------------------------------------------------------------------
// sirt_pkg
// Shared widths, register codes, character constants and payload types for
// the signed integer to radix text block.
// ----------------------------------------------------------------------------
package sirt_pkg;

   // field and datapath widths
   localparam int DATA_W      = 32;
   localparam int CHAR_W      = 8;
   localparam int CFG_W       = 64;
   localparam int RADIX_W     = 5;
   localparam int DIGIT_W     = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int MAX_RADIX   = 16;
   localparam int MIN_RADIX   = 2;
   localparam int STACK_DEPTH = DATA_W;
   localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int DIV_CNT_W   = $clog2(DATA_W);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHABET_LOW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHABET_HI  = 2'd2;

   // characters of note
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CTRL_LOW   = 8'd9;
   localparam logic [CHAR_W-1:0] CTRL_HIGH  = 8'd13;

   // alphabet, character 0 in the lowest byte
   typedef logic [MAX_RADIX-1:0][CHAR_W-1:0] alpha_type;

   // validator result
   typedef struct packed {
      logic done;
      logic ok;
   } chk_status_type;

   // divider result
   typedef struct packed {
      logic               done;
      logic [DATA_W-1:0]  quotient;
      logic [DIGIT_W-1:0] remainder;
   } div_status_type;

   // digit stack control
   typedef struct packed {
      logic               push;
      logic               pop;
      logic [DIGIT_W-1:0] digit;
   } stk_ctl_type;

endpackage

FILE: src/sirt_if.sv
// ----------------------------------------------------------------------------
// sirt_if
// Valid/ready channels of the signed integer to radix text block: number
// input, character output and register write.
// ----------------------------------------------------------------------------
interface sirt_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [sirt_pkg::DATA_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sirt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sirt_pkg::CHAR_W-1:0] character;
   logic                        last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

interface sirt_csr_if;
   logic                           valid;
   logic                           ready;
   logic [sirt_pkg::CSR_IDX_W-1:0] index;
   logic [sirt_pkg::CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/sirt_check.sv
// ----------------------------------------------------------------------------
// sirt_check
// Alphabet validator: walks the characters in use one per cycle, checking
// each for forbidden bytes and against all later characters for repeats.
// ----------------------------------------------------------------------------
module sirt_check (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [sirt_pkg::RADIX_W-1:0]     base_length,
   input  sirt_pkg::alpha_type              alphabet,
   output sirt_pkg::chk_status_type         status
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic                         ok_ff, ok_in;
   logic [sirt_pkg::RADIX_W-1:0] idx_ff, idx_in;
   logic [sirt_pkg::CHAR_W-1:0]  cur_char;
   logic                         len_bad;
   logic                         char_bad;
   logic                         dup_hit;

   // length outside the usable radix range
   assign len_bad = (base_length < sirt_pkg::RADIX_W'(sirt_pkg::MIN_RADIX))
                 || (base_length > sirt_pkg::RADIX_W'(sirt_pkg::MAX_RADIX));

   assign cur_char = alphabet[idx_ff[sirt_pkg::DIGIT_W-1:0]];

   // forbidden byte test and repeat search over later characters
   always_comb begin
      char_bad = cur_char inside {sirt_pkg::CHAR_MINUS, sirt_pkg::CHAR_PLUS,
                                  sirt_pkg::CHAR_SPACE, sirt_pkg::CHAR_NUL,
                                  [sirt_pkg::CTRL_LOW:sirt_pkg::CTRL_HIGH]};
      dup_hit = 1'b0;
      for (int j = 0; j < sirt_pkg::MAX_RADIX; j++) begin
         if ((sirt_pkg::RADIX_W'(j) > idx_ff) && (sirt_pkg::RADIX_W'(j) < base_length)
             && (alphabet[j] == cur_char)) begin
            dup_hit = 1'b1;
         end
      end
   end

   // walk sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ok_in   = ok_ff;
      idx_in  = idx_ff;
      if (start) begin
         idx_in = '0;
         if (len_bad) begin
            done_in = 1'b1;
            ok_in   = 1'b0;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (char_bad || dup_hit) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            ok_in   = 1'b0;
         end else if (idx_ff == base_length - 1'b1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            ok_in   = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         ok_ff   <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         ok_ff   <= ok_in;
         idx_ff  <= idx_in;
      end
   end

   assign status.done = done_ff;
   assign status.ok   = ok_ff;

endmodule

FILE: src/sirt_divider.sv
// ----------------------------------------------------------------------------
// sirt_divider
// Bit-serial restoring divider: divides the magnitude by the radix one
// quotient bit per cycle, giving the quotient and the remainder digit.
// ----------------------------------------------------------------------------
module sirt_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [sirt_pkg::DATA_W-1:0]      dividend,
   input  logic [sirt_pkg::RADIX_W-1:0]     radix,
   output sirt_pkg::div_status_type         status
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [sirt_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [sirt_pkg::DATA_W-1:0]    quo_ff, quo_in;
   logic [sirt_pkg::DIGIT_W-1:0]   rem_ff, rem_in;
   logic [sirt_pkg::RADIX_W-1:0]   trial;
   logic [sirt_pkg::RADIX_W-1:0]   diff;
   logic                           fits;

   // one restoring step: bring down the next dividend bit
   assign trial = {rem_ff, quo_ff[sirt_pkg::DATA_W-1]};
   assign fits  = trial >= radix;
   assign diff  = trial - radix;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[sirt_pkg::DATA_W-2:0], fits};
         rem_in = fits ? diff[sirt_pkg::DIGIT_W-1:0] : trial[sirt_pkg::DIGIT_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == sirt_pkg::DIV_CNT_W'(sirt_pkg::DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign status.done      = done_ff;
   assign status.quotient  = quo_ff;
   assign status.remainder = rem_ff;

endmodule

FILE: src/sirt_stack.sv
// ----------------------------------------------------------------------------
// sirt_stack
// Digit stack as a shift register: digits enter least significant first and
// leave from the same end, so they come out most significant first.
// ----------------------------------------------------------------------------
module sirt_stack (
   input  logic                               clock,
   input  logic                               reset,
   input  sirt_pkg::stk_ctl_type              ctl,
   output logic [sirt_pkg::DIGIT_W-1:0]       top,
   output logic [sirt_pkg::STACK_CNT_W-1:0]   count
);

   logic [sirt_pkg::DIGIT_W-1:0]     entry_ff [sirt_pkg::STACK_DEPTH];
   logic [sirt_pkg::DIGIT_W-1:0]     entry_in [sirt_pkg::STACK_DEPTH];
   logic [sirt_pkg::STACK_CNT_W-1:0] count_ff, count_in;

   // shift up on push, down on pop
   always_comb begin
      count_in = count_ff;
      for (int k = 0; k < sirt_pkg::STACK_DEPTH; k++) begin
         entry_in[k] = entry_ff[k];
      end
      if (ctl.push) begin
         entry_in[0] = ctl.digit;
         for (int k = 1; k < sirt_pkg::STACK_DEPTH; k++) begin
            entry_in[k] = entry_ff[k-1];
         end
         count_in = count_ff + 1'b1;
      end else if (ctl.pop) begin
         for (int k = 0; k < sirt_pkg::STACK_DEPTH - 1; k++) begin
            entry_in[k] = entry_ff[k+1];
         end
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < sirt_pkg::STACK_DEPTH; k++) begin
         entry_ff[k] <= entry_in[k];
      end
   end

   assign top   = entry_ff[0];
   assign count = count_ff;

endmodule

FILE: src/signed_integer_to_radix_text_top.sv
// Operation: checks the alphabet (a rejected one prints nothing), then one division
// per digit on the 32-step serial divider, then one character per cycle to the
// output while the output slot is free. A new number is taken only once the last
// character of the previous one has been issued.
// Reset: synchronous, active high; clears control state and the configuration registers.
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_top
// Prints a signed 32-bit value in the radix set by a configured alphabet,
// one character per output transaction, with a leading minus when negative.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text_top (
   input  logic          clock,
   input  logic          reset,
   sirt_req_if.sink      req_chan,
   sirt_rsp_if.source    rsp_chan,
   sirt_csr_if.sink      csr_chan
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_SIGN  = 3'd3;
   localparam logic [2:0] ST_DIGIT = 3'd4;

   logic [2:0]                       state_ff, state_in;
   logic                             neg_ff, neg_in;
   logic [sirt_pkg::DATA_W-1:0]      mag_ff, mag_in;
   logic [sirt_pkg::RADIX_W-1:0]     base_len_ff;
   logic [sirt_pkg::CFG_W-1:0]       alpha_low_ff;
   logic [sirt_pkg::CFG_W-1:0]       alpha_high_ff;
   sirt_pkg::alpha_type              alphabet;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [sirt_pkg::CHAR_W-1:0]      char_ff, char_in;
   logic                             last_ff, last_in;
   logic                             rsp_free;
   logic [sirt_pkg::DATA_W-1:0]      value_u;
   logic                             chk_start;
   sirt_pkg::chk_status_type         chk_status;
   logic                             div_start;
   logic [sirt_pkg::DATA_W-1:0]      div_dividend;
   sirt_pkg::div_status_type         div_status;
   sirt_pkg::stk_ctl_type            stk_ctl;
   logic [sirt_pkg::DIGIT_W-1:0]     stk_top;
   logic [sirt_pkg::STACK_CNT_W-1:0] stk_count;

   assign alphabet = sirt_pkg::alpha_type'({alpha_high_ff, alpha_low_ff});
   assign value_u  = sirt_pkg::DATA_W'(unsigned'(req_chan.value));

   // register writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_len_ff   <= '0;
         alpha_low_ff  <= '0;
         alpha_high_ff <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            sirt_pkg::CSR_BASE_LENGTH: begin
               base_len_ff <= csr_chan.data[sirt_pkg::RADIX_W-1:0];
            end
            sirt_pkg::CSR_ALPHABET_LOW: begin
               alpha_low_ff <= csr_chan.data;
            end
            sirt_pkg::CSR_ALPHABET_HI: begin
               alpha_high_ff <= csr_chan.data;
            end
            default: begin
            end
         endcase
      end
   end

   // sub-units
   sirt_check u_check (
      .clock       (clock),
      .reset       (reset),
      .start       (chk_start),
      .base_length (base_len_ff),
      .alphabet    (alphabet),
      .status      (chk_status)
   );

   sirt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .radix    (base_len_ff),
      .status   (div_status)
   );

   sirt_stack u_stack (
      .clock (clock),
      .reset (reset),
      .ctl   (stk_ctl),
      .top   (stk_top),
      .count (stk_count)
   );

   // output slot can take a character this cycle
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      chk_start     = 1'b0;
      div_start     = 1'b0;
      div_dividend  = mag_ff;
      stk_ctl.push  = 1'b0;
      stk_ctl.pop   = 1'b0;
      stk_ctl.digit = div_status.remainder;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      char_in       = char_ff;
      last_in       = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               neg_in    = value_u[sirt_pkg::DATA_W-1];
               mag_in    = value_u[sirt_pkg::DATA_W-1] ? (~value_u + 1'b1) : value_u;
               chk_start = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (chk_status.done) begin
               if (chk_status.ok) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               stk_ctl.push = 1'b1;
               if (div_status.quotient == '0) begin
                  state_in = neg_ff ? ST_SIGN : ST_DIGIT;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = div_status.quotient;
               end
            end
         end
         ST_SIGN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               char_in      = sirt_pkg::CHAR_MINUS;
               last_in      = 1'b0;
               state_in     = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (rsp_free) begin
               stk_ctl.pop  = 1'b1;
               rsp_valid_in = 1'b1;
               char_in      = alphabet[stk_top];
               last_in      = (stk_count == sirt_pkg::STACK_CNT_W'(1));
               if (stk_count == sirt_pkg::STACK_CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.character = char_ff;
   assign rsp_chan.last      = last_ff;

endmodule

FILE: src/sirt_checker.sv
// ----------------------------------------------------------------------------
// sirt_checker
// Port-level checks on the signed integer to radix text block, attached to
// the top level by a bind.
// ----------------------------------------------------------------------------
module sirt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [sirt_pkg::CHAR_W-1:0] rsp_character,
   input logic                        rsp_last
);

   // no character pending straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

   // a stalled character holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("stalled output changed");

   // a number in work blocks the next input transaction
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while busy");

   // the minus sign is never the final character
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_character == sirt_pkg::CHAR_MINUS && rsp_last))
      else $error("minus sign flagged last");

endmodule

bind signed_integer_to_radix_text_top sirt_checker u_sirt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_character (rsp_chan.character),
   .rsp_last      (rsp_chan.last)
);

FILE: tb/signed_integer_to_radix_text_top_tb.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_top_tb
// Self-checking bench for the radix text printer. A short table of numbers
// and alphabets (reset state, extremes, every kind of bad alphabet) is run
// first, then random alphabets and values with random idling on both
// channels and one long output hold-off. Every output character is compared
// with the text given in the table or from a predictor kept inside the bench.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // run shape
   localparam int RANDOM_ITEMS = 370;
   localparam int DRAIN_CYCLES = 1200;
   localparam int HOLD_CYCLES  = 6000;
   localparam int HOLD_AFTER   = 200;
   localparam int TIMEOUT_NS   = 50_000_000;

   // alphabets used by the directed table, character 0 in the lowest byte
   localparam logic [sirt_pkg::CFG_W-1:0] DEC_LOW      = 64'h3736_3534_3332_3130;
   localparam logic [sirt_pkg::CFG_W-1:0] DEC_HIGH     = 64'h0000_0000_0000_3938;
   localparam logic [sirt_pkg::CFG_W-1:0] HEX_HIGH     = 64'h6665_6463_6261_3938;
   localparam logic [sirt_pkg::CFG_W-1:0] HEX_DUP_HIGH = 64'h3065_6463_6261_3938;
   localparam logic [sirt_pkg::CFG_W-1:0] PLUS_LOW     =
      {40'd0, sirt_pkg::CHAR_PLUS, 8'h31, 8'h30};
   localparam logic [sirt_pkg::CFG_W-1:0] MINUS_LOW    =
      {40'd0, sirt_pkg::CHAR_MINUS, 8'h31, 8'h30};
   localparam logic [sirt_pkg::CFG_W-1:0] SPACE_LOW    =
      {40'd0, sirt_pkg::CHAR_SPACE, 8'h31, 8'h30};
   localparam logic [sirt_pkg::CFG_W-1:0] TAB_LOW      =
      {40'd0, sirt_pkg::CTRL_LOW, 8'h31, 8'h30};
   localparam logic [sirt_pkg::CFG_W-1:0] CR_LOW       =
      {40'd0, sirt_pkg::CTRL_HIGH, 8'h31, 8'h30};
   localparam logic [sirt_pkg::CFG_W-1:0] NUL_LOW      =
      {40'd0, sirt_pkg::CHAR_NUL, 8'h31, 8'h30};
   localparam logic [sirt_pkg::CFG_W-1:0] HIGH_BYTES   = 64'h0000_0000_00FF_8041;
   localparam logic [sirt_pkg::CFG_W-1:0] EDGE_BYTES   = 64'h0000_0000_7F0E_0841;

   typedef struct packed {
      logic [sirt_pkg::CHAR_W-1:0] character;
      logic                        last;
   } printed_char_type;

   typedef struct {
      logic [sirt_pkg::RADIX_W-1:0]       radix;
      logic [sirt_pkg::CFG_W-1:0]         letters_low;
      logic [sirt_pkg::CFG_W-1:0]         letters_high;
      logic signed [sirt_pkg::DATA_W-1:0] num;
      bit                                 typed;
      string                              text;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 26;

   // directed table: text given only where it is obvious, else predicted
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{5'd0,  64'd0,      64'd0,        32'sd0,             1'b1, ""},
      '{5'd0,  64'd0,      64'd0,        32'sh7FFF_FFFF,     1'b1, ""},
      '{5'd10, DEC_LOW,    DEC_HIGH,     32'sd0,             1'b1, "0"},
      '{5'd10, DEC_LOW,    DEC_HIGH,     32'sh7FFF_FFFF,     1'b1, "2147483647"},
      '{5'd10, DEC_LOW,    DEC_HIGH,     32'sh8000_0000,     1'b1, "-2147483648"},
      '{5'd10, DEC_LOW,    DEC_HIGH,     -32'sd1,            1'b1, "-1"},
      '{5'd10, DEC_LOW,    DEC_HIGH,     32'sd987654321,     1'b0, ""},
      '{5'd16, DEC_LOW,    HEX_HIGH,     32'sh8000_0000,     1'b1, "-80000000"},
      '{5'd16, DEC_LOW,    HEX_HIGH,     32'sh7FFF_FFFF,     1'b1, "7fffffff"},
      '{5'd16, DEC_LOW,    HEX_HIGH,     32'shDEAD_BEEF,     1'b0, ""},
      '{5'd2,  DEC_LOW,    DEC_HIGH,     32'sh8000_0000,     1'b0, ""},
      '{5'd2,  DEC_LOW,    DEC_HIGH,     -32'sd1,            1'b1, "-1"},
      '{5'd2,  DEC_LOW,    DEC_HIGH,     32'sh7FFF_FFFF,     1'b0, ""},
      '{5'd8,  DEC_LOW,    DEC_HIGH,     32'sd123456,        1'b0, ""},
      '{5'd1,  DEC_LOW,    DEC_HIGH,     32'sd5,             1'b1, ""},
      '{5'd17, DEC_LOW,    HEX_HIGH,     32'sd5,             1'b1, ""},
      '{5'd31, DEC_LOW,    HEX_HIGH,     32'sd5,             1'b1, ""},
      '{5'd3,  PLUS_LOW,   64'd0,        32'sd5,             1'b1, ""},
      '{5'd3,  MINUS_LOW,  64'd0,        32'sd5,             1'b1, ""},
      '{5'd3,  SPACE_LOW,  64'd0,        32'sd5,             1'b1, ""},
      '{5'd3,  TAB_LOW,    64'd0,        32'sd5,             1'b1, ""},
      '{5'd3,  CR_LOW,     64'd0,        32'sd5,             1'b1, ""},
      '{5'd3,  NUL_LOW,    64'd0,        32'sd5,             1'b1, ""},
      '{5'd16, DEC_LOW,    HEX_DUP_HIGH, 32'sd5,             1'b1, ""},
      '{5'd3,  HIGH_BYTES, 64'd0,        -32'sd100,          1'b0, ""},
      '{5'd4,  EDGE_BYTES, 64'd0,        32'sd1000,          1'b0, ""}
   };

   logic clock = 1'b0;
   logic reset;

   sirt_req_if req_if ();
   sirt_rsp_if rsp_if ();
   sirt_csr_if csr_if ();

   signed_integer_to_radix_text_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // bench copy of the registers
   logic [sirt_pkg::RADIX_W-1:0] cfg_radix   = '0;
   sirt_pkg::alpha_type          cfg_letters = '0;

   // characters still to come, oldest first
   printed_char_type pending_chars [$];
   printed_char_type oldest_char;
   int               fail_count  = 0;

   // idling and hold-off control
   int req_gap_pct = 22;
   int rsp_gap_pct = 46;
   bit hold_go     = 1'b0;
   bit hold_on     = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // characters that may not stand in an alphabet
   function automatic bit bad_glyph(input logic [sirt_pkg::CHAR_W-1:0] c);
      return c == sirt_pkg::CHAR_NUL || c == sirt_pkg::CHAR_SPACE
             || c == sirt_pkg::CHAR_PLUS || c == sirt_pkg::CHAR_MINUS
             || (c >= sirt_pkg::CTRL_LOW && c <= sirt_pkg::CTRL_HIGH);
   endfunction

   function automatic bit alphabet_usable();
      int i, j;
      if (cfg_radix < sirt_pkg::MIN_RADIX || cfg_radix > sirt_pkg::MAX_RADIX) return 1'b0;
      for (i = 0; i < cfg_radix; i++) begin
         if (bad_glyph(cfg_letters[i])) return 1'b0;
         for (j = i + 1; j < cfg_radix; j++)
            if (cfg_letters[i] == cfg_letters[j]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // text of one number under the current alphabet, queued as pending
   function automatic void predict_text(input logic signed [sirt_pkg::DATA_W-1:0] num);
      logic [sirt_pkg::DATA_W-1:0]  magnitude;
      logic [sirt_pkg::DIGIT_W-1:0] digits [$];
      printed_char_type             glyph_item;
      int                           k;
      if (!alphabet_usable()) return;
      magnitude = num;
      if (num < 0) begin
         magnitude = 32'd0 - magnitude;
         glyph_item.character = sirt_pkg::CHAR_MINUS;
         glyph_item.last      = 1'b0;
         pending_chars.push_back(glyph_item);
      end
      do begin
         digits.push_front(sirt_pkg::DIGIT_W'(magnitude % cfg_radix));
         magnitude = magnitude / cfg_radix;
      end while (magnitude != 0);
      for (k = 0; k < digits.size(); k++) begin
         glyph_item.character = cfg_letters[digits[k]];
         glyph_item.last      = (k == digits.size() - 1);
         pending_chars.push_back(glyph_item);
      end
   endfunction

   // register write, valid left high for a following write
   task automatic csr_write(input logic [sirt_pkg::CSR_IDX_W-1:0] index,
                            input logic [sirt_pkg::CFG_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      case (index)
         sirt_pkg::CSR_BASE_LENGTH:  cfg_radix = data[sirt_pkg::RADIX_W-1:0];
         sirt_pkg::CSR_ALPHABET_LOW: cfg_letters[7:0] = data;
         sirt_pkg::CSR_ALPHABET_HI:  cfg_letters[15:8] = data;
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [sirt_pkg::RADIX_W-1:0] radix,
                                input logic [sirt_pkg::CFG_W-1:0] low_chars,
                                input logic [sirt_pkg::CFG_W-1:0] high_chars);
      logic [sirt_pkg::CFG_W-1:0] radix_word;
      radix_word                            = {$urandom, $urandom};
      radix_word[sirt_pkg::RADIX_W-1:0]     = radix;
      csr_write(sirt_pkg::CSR_BASE_LENGTH, radix_word);
      csr_write(sirt_pkg::CSR_ALPHABET_LOW, low_chars);
      csr_write(sirt_pkg::CSR_ALPHABET_HI, high_chars);
      csr_if.valid <= 1'b0;
   endtask

   // offer one number, return once the transaction is taken
   task automatic offer_value(input logic signed [sirt_pkg::DATA_W-1:0] num);
      while ($urandom_range(99) < req_gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.value <= num;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // wait until every pending character is out and the block has gone quiet
   task automatic settle();
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // receiver ready with random idling and the long hold-off
   always @(posedge clock) begin
      if (reset || hold_on) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_gap_pct);
      end
   end

   // long receiver hold-off, counted here
   initial begin : receiver_hold
      wait (hold_go);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   // output check against the oldest pending character
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_chars.size() == 0) begin
            $error("character 8'h%h (last %b) arrived with nothing pending",
                   rsp_if.character, rsp_if.last);
            fail_count++;
         end else begin
            oldest_char = pending_chars.pop_front();
            if (rsp_if.character !== oldest_char.character) begin
               $error("character: expected 8'h%h, actual 8'h%h",
                      oldest_char.character, rsp_if.character);
               fail_count++;
            end
            if (rsp_if.last !== oldest_char.last) begin
               $error("last: expected %b, actual %b", oldest_char.last, rsp_if.last);
               fail_count++;
            end
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      int                                 row, n, i, j, items_in_phase, counted_items;
      logic [sirt_pkg::RADIX_W-1:0]       radix;
      sirt_pkg::alpha_type                letters;
      logic signed [sirt_pkg::DATA_W-1:0] num;
      logic [sirt_pkg::CHAR_W-1:0]        bad_char;
      bit                                 clash, usable, hold_done;
      printed_char_type                   glyph_item;

      counted_items = 0;
      hold_done     = 1'b0;

      // known levels from time zero, then reset
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.value = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = sirt_pkg::CSR_BASE_LENGTH;
      csr_if.data  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (directed_rows[row].radix !== cfg_radix ||
             {directed_rows[row].letters_high, directed_rows[row].letters_low}
                !== cfg_letters) begin
            req_if.valid <= 1'b0;
            settle();
            apply_setting(directed_rows[row].radix, directed_rows[row].letters_low,
                          directed_rows[row].letters_high);
         end
         offer_value(directed_rows[row].num);
         if (directed_rows[row].typed) begin
            for (i = 0; i < directed_rows[row].text.len(); i++) begin
               glyph_item.character = directed_rows[row].text[i];
               glyph_item.last      = (i == directed_rows[row].text.len() - 1);
               pending_chars.push_back(glyph_item);
            end
         end else begin
            predict_text(directed_rows[row].num);
         end
      end
      req_if.valid <= 1'b0;
      settle();

      // random alphabets and numbers, one alphabet per phase
      while (counted_items < RANDOM_ITEMS) begin
         if (counted_items < RANDOM_ITEMS / 3) begin
            req_gap_pct = 22;
            rsp_gap_pct <= 46;
         end else if (counted_items < 2 * RANDOM_ITEMS / 3) begin
            req_gap_pct = 46;
            rsp_gap_pct <= 22;
         end else begin
            req_gap_pct = 0;
            rsp_gap_pct <= 0;
         end

         // distinct usable characters in use, anything beyond the radix
         radix   = sirt_pkg::RADIX_W'($urandom_range(sirt_pkg::MIN_RADIX,
                                                     sirt_pkg::MAX_RADIX));
         letters = {$urandom, $urandom, $urandom, $urandom};
         for (i = 0; i < radix; i++) begin
            do begin
               letters[i] = sirt_pkg::CHAR_W'($urandom_range(0, 255));
               clash      = bad_glyph(letters[i]);
               for (j = 0; j < i; j++)
                  if (letters[j] == letters[i]) clash = 1'b1;
            end while (clash);
         end

         // some phases break the alphabet on purpose
         if ($urandom_range(99) < 20) begin
            case ($urandom_range(0, 3))
               0: radix = sirt_pkg::RADIX_W'($urandom_range(0, sirt_pkg::MIN_RADIX - 1));
               1: radix = sirt_pkg::RADIX_W'($urandom_range(sirt_pkg::MAX_RADIX + 1, 31));
               2: begin
                  case ($urandom_range(0, 4))
                     0:       bad_char = sirt_pkg::CHAR_NUL;
                     1:       bad_char = sirt_pkg::CHAR_SPACE;
                     2:       bad_char = sirt_pkg::CHAR_PLUS;
                     3:       bad_char = sirt_pkg::CHAR_MINUS;
                     default: bad_char = sirt_pkg::CHAR_W'($urandom_range(
                                            sirt_pkg::CTRL_LOW, sirt_pkg::CTRL_HIGH));
                  endcase
                  letters[$urandom_range(0, radix - 1)] = bad_char;
               end
               default: begin
                  i          = $urandom_range(0, radix - 1);
                  j          = (i + $urandom_range(1, radix - 1)) % radix;
                  letters[j] = letters[i];
               end
            endcase
         end

         apply_setting(radix, letters[7:0], letters[15:8]);
         usable         = alphabet_usable();
         items_in_phase = usable ? $urandom_range(10, 30) : $urandom_range(3, 6);

         // one long receiver hold-off while numbers keep coming
         if (!hold_done && usable && counted_items >= HOLD_AFTER) begin
            hold_go        = 1'b1;
            hold_done      = 1'b1;
            items_in_phase = 24;
         end

         for (n = 0; n < items_in_phase; n++) begin
            case ($urandom_range(0, 7))
               0: begin
                  case ($urandom_range(0, 6))
                     0:       num = 32'sd0;
                     1:       num = -32'sd1;
                     2:       num = 32'sh7FFF_FFFF;
                     3:       num = 32'sh8000_0000;
                     4:       num = sirt_pkg::DATA_W'(radix);
                     5:       num = sirt_pkg::DATA_W'(radix) - 1;
                     default: begin
                        num = sirt_pkg::DATA_W'(radix);
                        num = -num;
                     end
                  endcase
               end
               1, 2, 3: begin
                  num = $urandom_range(0, 999);
                  if ($urandom_range(0, 1)) num = -num;
               end
               default: num = $urandom;
            endcase
            offer_value(num);
            predict_text(num);
            if (usable) counted_items++;
         end
         req_if.valid <= 1'b0;
         settle();
      end

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: files.f
src/sirt_pkg.sv
src/sirt_if.sv
src/sirt_check.sv
src/sirt_divider.sv
src/sirt_stack.sv
src/signed_integer_to_radix_text_top.sv
src/sirt_checker.sv
tb/signed_integer_to_radix_text_top_tb.sv
